// ===== hw/rtl/ssbt_pkg.sv =====
`timescale 1ns / 1ps
package ssbt_pkg;

    // input modes
    localparam logic [2:0] MODE_APPEND = 3'd0;
    localparam logic [2:0] MODE_WROTE  = 3'd1;
    localparam logic [2:0] MODE_ACK    = 3'd2;
    localparam logic [2:0] MODE_REVERT = 3'd3;
    localparam logic [2:0] MODE_LIST   = 3'd4;

    // classified command kinds
    localparam logic [2:0] K_APPEND = 3'd0;
    localparam logic [2:0] K_WROTE  = 3'd1;
    localparam logic [2:0] K_ACK    = 3'd2;
    localparam logic [2:0] K_REVERT = 3'd3;
    localparam logic [2:0] K_LIST   = 3'd4;
    localparam logic [2:0] K_BAD    = 3'd5;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_LEN   = 2'd1;
    localparam logic [1:0] ERR_COUNT = 2'd2;
    localparam logic [1:0] ERR_MODE  = 2'd3;

    // alarm events
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_RAISED  = 2'd1;
    localparam logic [1:0] EV_CLEARED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WM_EN    = 2'd0;
    localparam logic [1:0] REG_ALARM    = 2'd1;
    localparam logic [1:0] REG_CLEAR    = 2'd2;
    localparam logic [1:0] REG_NOTIFY   = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] byte_count;
    } t_in;

    typedef struct packed {
        logic        seg_valid;
        logic [3:0]  seg_index;
        logic [15:0] seg_offset;
        logic [15:0] seg_length;
        logic        is_last;
        logic        more_pending;
        logic [31:0] unsent_bytes;
        logic [31:0] unack_bytes;
        logic [47:0] acked_total;
        logic        alarm_on;
        logic [1:0]  alarm_event;
        logic [1:0]  error;
    } t_out;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] count;
    } t_cmd;

    typedef struct packed {
        logic        wm_enable;
        logic [31:0] alarm_level;
        logic [31:0] clear_level;
        logic        notify_enable;
        logic        notify_wr;
    } t_cfg;

endpackage

// ===== hw/rtl/ssbt_front.sv =====
`timescale 1ns / 1ps
module ssbt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ssbt_pkg::t_in i_item,
    output logic          o_busy,
    input  logic          i_pop,
    output logic          o_head_valid,
    output ssbt_pkg::t_cmd o_head
);
    import ssbt_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd;

    // classify the incoming mode
    always_comb begin
        cmd.count = i_item.byte_count;
        case (i_item.mode)
            MODE_APPEND: cmd.kind = K_APPEND;
            MODE_WROTE:  cmd.kind = K_WROTE;
            MODE_ACK:    cmd.kind = K_ACK;
            MODE_REVERT: cmd.kind = K_REVERT;
            MODE_LIST:   cmd.kind = K_LIST;
            default:     cmd.kind = K_BAD;
        endcase
    end

    assign o_busy       = (r_cnt == 2'd2);
    assign push         = i_start && !o_busy;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("push lost");
`endif
endmodule

// ===== hw/rtl/ssbt_back.sv =====
`timescale 1ns / 1ps
module ssbt_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ssbt_pkg::t_cfg i_cfg,
    input  logic           i_head_valid,
    input  ssbt_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_res_valid,
    output ssbt_pkg::t_out o_res
);
    import ssbt_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LB = LENGTH_BITS;
    localparam logic [CW:0] DEP     = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ALARM  = 4'd1;
    localparam logic [3:0] S_EMIT   = 4'd2;
    localparam logic [3:0] S_WR_RD  = 4'd3;
    localparam logic [3:0] S_WR_DAT = 4'd4;
    localparam logic [3:0] S_AK_RD  = 4'd5;
    localparam logic [3:0] S_AK_DAT = 4'd6;
    localparam logic [3:0] S_LS_RD  = 4'd7;
    localparam logic [3:0] S_LS_DAT = 4'd8;
    localparam logic [3:0] S_LE_RD  = 4'd9;
    localparam logic [3:0] S_LE_DAT = 4'd10;

    typedef struct packed {
        logic [3:0]    state;
        logic [2:0]    kind;
        logic [31:0]   b;
        logic [AW-1:0] front;
        logic [CW-1:0] count;
        logic [CW-1:0] cursor;
        logic [LB-1:0] off;
        logic [31:0]   unsent;
        logic [31:0]   unacked;
        logic [47:0]   acked;
        logic          alarm;
        logic          notify;
        logic [1:0]    ev;
        logic [1:0]    err;
        logic          e_valid;
        logic          e_more;
        logic [CW-1:0] i;
        logic [36:0]   total;
        logic [4:0]    n;
        logic [4:0]    k;
        logic          more;
    } t_bk_state;

    t_bk_state     r_st, n_st;
    logic [LB-1:0] mem [QUEUE_DEPTH];
    logic [LB-1:0] r_rd;
    logic          r_res_valid;
    t_out          r_res;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, rd_addr;
    logic [LB-1:0] mem_wdata, off_i, seg, rem;
    logic          res_stb, wm_active;
    t_out          res;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
                                              input logic [CW-1:0] pos);
        logic [CW:0] sum;
        sum = (CW + 1)'(front) + (CW + 1)'(pos);
        if (sum >= DEP) sum = sum - DEP;
        return AW'(sum);
    endfunction

    assign wm_active = i_cfg.wm_enable && (i_cfg.clear_level < i_cfg.alarm_level);
    assign off_i     = (r_st.i == r_st.cursor) ? r_st.off : '0;
    assign seg       = (r_rd > off_i) ? r_rd - off_i : '0;
    assign rem       = (r_rd > r_st.off) ? r_rd - r_st.off : '0;

    // sequencer for one command at a time
    always_comb begin
        n_st      = r_st;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        rd_addr   = '0;
        res_stb   = 1'b0;
        res       = '0;
        res.unsent_bytes  = r_st.unsent;
        res.unack_bytes   = r_st.unacked;
        res.acked_total   = r_st.acked;
        res.alarm_on      = r_st.alarm;
        case (r_st.state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop        = 1'b1;
                    n_st.kind    = i_head.kind;
                    n_st.b       = i_head.count;
                    n_st.ev      = EV_NONE;
                    n_st.err     = ERR_OK;
                    n_st.e_valid = 1'b0;
                    n_st.e_more  = 1'b0;
                    n_st.state   = S_EMIT;
                    case (i_head.kind)
                        K_APPEND: begin
                            if (i_head.count == 32'd0 || {1'b0, i_head.count} > LEN_MAX
                                    || {1'b0, r_st.count} >= DEP) begin
                                n_st.err = ERR_LEN;
                            end else if ({1'b0, r_st.unsent} + {1'b0, i_head.count}
                                    > 33'h0FFFFFFFF) begin
                                n_st.err = ERR_COUNT;
                            end else begin
                                mem_we      = 1'b1;
                                mem_waddr   = slot_of(r_st.front, r_st.count);
                                mem_wdata   = LB'(i_head.count);
                                n_st.count  = r_st.count + CW'(1);
                                n_st.unsent = r_st.unsent + i_head.count;
                                n_st.state  = S_ALARM;
                            end
                        end
                        K_WROTE: begin
                            if (i_head.count > r_st.unsent) begin
                                n_st.err = ERR_COUNT;
                            end else begin
                                n_st.unacked = r_st.unacked + i_head.count;
                                n_st.unsent  = r_st.unsent - i_head.count;
                                n_st.notify  = 1'b0;
                                n_st.state   = S_ALARM;
                            end
                        end
                        K_ACK: begin
                            if (i_head.count > r_st.unacked) begin
                                n_st.err = ERR_COUNT;
                            end else begin
                                n_st.unacked = r_st.unacked - i_head.count;
                                n_st.acked   = r_st.acked + 48'(i_head.count);
                                n_st.state   = S_AK_RD;
                            end
                        end
                        K_REVERT: begin
                            n_st.unsent  = r_st.unsent + r_st.unacked;
                            n_st.unacked = '0;
                            n_st.cursor  = '0;
                            n_st.off     = '0;
                            if (i_cfg.notify_enable) n_st.notify = 1'b1;
                        end
                        K_LIST: begin
                            if (r_st.count == '0 || r_st.unsent == 32'd0) begin
                                n_st.e_valid = r_st.notify;
                            end else begin
                                n_st.i     = r_st.cursor;
                                n_st.total = '0;
                                n_st.n     = '0;
                                n_st.state = S_LS_RD;
                            end
                        end
                        default: n_st.err = ERR_MODE;
                    endcase
                end
            end
            // watermark hysteresis on the new unsent count
            S_ALARM: begin
                if (wm_active) begin
                    if (r_st.alarm) begin
                        if (r_st.unsent <= i_cfg.clear_level) begin
                            n_st.alarm = 1'b0;
                            n_st.ev    = EV_CLEARED;
                        end
                    end else if (r_st.unsent >= i_cfg.alarm_level) begin
                        n_st.alarm = 1'b1;
                        n_st.ev    = EV_RAISED;
                    end
                end
                n_st.state = (r_st.kind == K_WROTE) ? S_WR_RD : S_EMIT;
            end
            S_EMIT: begin
                res_stb           = 1'b1;
                res.seg_valid     = r_st.e_valid;
                res.is_last       = 1'b1;
                res.more_pending  = r_st.e_more;
                res.alarm_event   = r_st.ev;
                res.error         = r_st.err;
                n_st.state        = S_IDLE;
            end
            // advance the send cursor over written bytes
            S_WR_RD: begin
                if (r_st.cursor < r_st.count && r_st.b != 32'd0) begin
                    rd_addr    = slot_of(r_st.front, r_st.cursor);
                    n_st.state = S_WR_DAT;
                end else begin
                    n_st.state = S_EMIT;
                end
            end
            S_WR_DAT: begin
                if (r_st.b < 32'(rem)) begin
                    n_st.off   = LB'(32'(r_st.off) + r_st.b);
                    n_st.state = S_EMIT;
                end else begin
                    n_st.b      = r_st.b - 32'(rem);
                    n_st.cursor = r_st.cursor + CW'(1);
                    n_st.off    = '0;
                    n_st.state  = S_WR_RD;
                end
            end
            // retire acknowledged bytes from the front
            S_AK_RD: begin
                if (r_st.b != 32'd0 && r_st.count != '0) begin
                    rd_addr    = r_st.front;
                    n_st.state = S_AK_DAT;
                end else begin
                    n_st.state = S_EMIT;
                end
            end
            S_AK_DAT: begin
                if (r_st.b >= 32'(r_rd)) begin
                    n_st.b     = r_st.b - 32'(r_rd);
                    n_st.front = slot_of(r_st.front, CW'(1));
                    n_st.count = r_st.count - CW'(1);
                    if (r_st.cursor != '0) n_st.cursor = r_st.cursor - CW'(1);
                    else n_st.off = '0;
                    n_st.state = S_AK_RD;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_st.front;
                    mem_wdata = r_rd - LB'(r_st.b);
                    if (r_st.cursor == '0) begin
                        n_st.off = (32'(r_st.off) >= r_st.b) ? r_st.off - LB'(r_st.b) : '0;
                    end
                    n_st.state = S_EMIT;
                end
            end
            // first pass: count segments within the budget
            S_LS_RD: begin
                if (r_st.i < r_st.count && r_st.total < 37'(r_st.b) && r_st.n < 5'd16) begin
                    rd_addr    = slot_of(r_st.front, r_st.i);
                    n_st.state = S_LS_DAT;
                end else begin
                    n_st.more = (r_st.i != r_st.count);
                    if (r_st.n == 5'd0) begin
                        n_st.e_more = 1'b1;
                        n_st.state  = S_EMIT;
                    end else begin
                        n_st.i     = r_st.cursor;
                        n_st.k     = '0;
                        n_st.state = S_LE_RD;
                    end
                end
            end
            S_LS_DAT: begin
                n_st.total = r_st.total + 37'(seg);
                n_st.i     = r_st.i + CW'(1);
                n_st.n     = r_st.n + 5'd1;
                n_st.state = S_LS_RD;
            end
            // second pass: emit one transaction per segment
            S_LE_RD: begin
                rd_addr    = slot_of(r_st.front, r_st.i);
                n_st.state = S_LE_DAT;
            end
            S_LE_DAT: begin
                res_stb          = 1'b1;
                res.seg_valid    = 1'b1;
                res.seg_index    = 4'(r_st.i);
                res.seg_offset   = 16'(off_i);
                res.seg_length   = 16'(seg);
                res.is_last      = (r_st.k == r_st.n - 5'd1);
                res.more_pending = r_st.more;
                n_st.i           = r_st.i + CW'(1);
                n_st.k           = r_st.k + 5'd1;
                n_st.state       = res.is_last ? S_IDLE : S_LE_RD;
            end
            default: n_st.state = S_IDLE;
        endcase
        // register side effects
        if (!wm_active) n_st.alarm = 1'b0;
        if (i_cfg.notify_wr) n_st.notify = i_cfg.notify_enable;
    end

    // length ring
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_res <= res;
        if (!i_rst_n) begin
            r_st        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_res_valid <= res_stb;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_cursor_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.cursor <= r_st.count) else $error("cursor beyond queued buffers");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_st.count} <= DEP) else $error("buffer count overflow");
    a_len_only_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.seg_length != 16'd0) |-> r_res.seg_valid)
        else $error("segment length on a non-segment transaction");
`endif
endmodule

// ===== hw/rtl/stream_send_buffer_tracker_core.sv =====
`timescale 1ns / 1ps
// Sequence: revert, errors and an empty list go straight to the result; append
//   passes the alarm check, acknowledge the front retire walk, wrote the alarm check
//   and the cursor walk. A list scans buffers, then emits one segment transaction
//   per segment. Throughput: one command at a time; a two-entry queue accepts
//   the next command meanwhile. Synchronous active-low reset clears the ring
//   state, counters, alarm and registers; the receiver cannot stall results.
module stream_send_buffer_tracker_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  ssbt_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_res_valid,
    output ssbt_pkg::t_out o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import ssbt_pkg::*;

    logic        r_wm_en, r_notify_en, r_notify_wr;
    logic [31:0] r_alarm_lvl, r_clear_lvl;
    logic        cfg_wr;
    t_cfg        cfg;
    logic        head_valid, pop;
    t_cmd        head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm_en     <= 1'b0;
            r_notify_en <= 1'b0;
            r_notify_wr <= 1'b0;
            r_alarm_lvl <= '0;
            r_clear_lvl <= '0;
        end else begin
            r_notify_wr <= cfg_wr && (i_cfg_index == REG_NOTIFY);
            if (cfg_wr) begin
                case (i_cfg_index)
                    REG_WM_EN:  r_wm_en     <= i_cfg_data[0];
                    REG_ALARM:  r_alarm_lvl <= i_cfg_data;
                    REG_CLEAR:  r_clear_lvl <= i_cfg_data;
                    REG_NOTIFY: r_notify_en <= i_cfg_data[0];
                    default:    r_wm_en     <= r_wm_en;
                endcase
            end
        end
    end

    assign cfg.wm_enable     = r_wm_en;
    assign cfg.alarm_level   = r_alarm_lvl;
    assign cfg.clear_level   = r_clear_lvl;
    assign cfg.notify_enable = r_notify_en;
    assign cfg.notify_wr     = r_notify_wr;

    ssbt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_item),
        .o_busy       (busy),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    ssbt_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res_valid  (o_res_valid),
        .o_res        (o_res)
    );
endmodule

// ===== bench/stream_send_buffer_tracker_core_test.sv =====
`timescale 1ns / 1ps
module stream_send_buffer_tracker_core_test;
    import ssbt_pkg::*;

    localparam int DEPTH     = 16;
    localparam int MAX_SEGS  = 16;
    localparam int CYCLE_CAP = 1000000;
    localparam logic [31:0] LEN_MAX = 32'h0000_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    t_in         i_item = '0;
    logic        busy;
    logic        o_res_valid;
    t_out        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    stream_send_buffer_tracker_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_item(i_item),
        .busy(busy), .o_res_valid(o_res_valid), .o_res(o_res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // shadow copy of the send queue accounting
    logic [15:0] sh_len [DEPTH];
    logic [3:0]  sh_front;
    int unsigned sh_count, sh_cur_idx;
    logic [15:0] sh_cur_off;
    logic [31:0] sh_unsent, sh_unacked;
    logic [47:0] sh_acked;
    logic        sh_alarm, sh_notify;
    logic        cf_wm_en, cf_notify;
    logic [31:0] cf_alarm, cf_clear;

    t_out expected_results[$];
    int   fail_count = 0;
    int   cycle_count = 0;
    bit   hold_cfg = 0;

    function automatic bit watermark_live();
        return cf_wm_en && (cf_clear < cf_alarm);
    endfunction

    function automatic logic [1:0] update_alarm();
        if (!watermark_live()) return EV_NONE;
        if (sh_alarm) begin
            if (sh_unsent <= cf_clear) begin
                sh_alarm = 1'b0;
                return EV_CLEARED;
            end
        end else if (sh_unsent >= cf_alarm) begin
            sh_alarm = 1'b1;
            return EV_RAISED;
        end
        return EV_NONE;
    endfunction

    function automatic t_out make_result(logic v, logic [3:0] idx, logic [15:0] off,
                                         logic [15:0] len, logic last, logic more,
                                         logic [1:0] ev, logic [1:0] err);
        t_out r;
        r.seg_valid = v; r.seg_index = idx; r.seg_offset = off; r.seg_length = len;
        r.is_last = last; r.more_pending = more;
        r.unsent_bytes = sh_unsent; r.unack_bytes = sh_unacked;
        r.acked_total = sh_acked; r.alarm_on = sh_alarm;
        r.alarm_event = ev; r.error = err;
        return r;
    endfunction

    function automatic void shadow_reset();
        for (int i = 0; i < DEPTH; i++) sh_len[i] = '0;
        sh_front = '0; sh_count = 0; sh_cur_idx = 0; sh_cur_off = '0;
        sh_unsent = '0; sh_unacked = '0; sh_acked = '0;
        sh_alarm = 0; sh_notify = 0;
        cf_wm_en = 0; cf_notify = 0; cf_alarm = '0; cf_clear = '0;
    endfunction

    function automatic void shadow_config(logic [1:0] idx, logic [31:0] val);
        case (idx)
            REG_WM_EN:  cf_wm_en = val[0];
            REG_ALARM:  cf_alarm = val;
            REG_CLEAR:  cf_clear = val;
            REG_NOTIFY: begin
                cf_notify = val[0];
                sh_notify = val[0];
            end
            default: ;
        endcase
        if (!watermark_live()) sh_alarm = 1'b0;
    endfunction

    // works out the results of one command and queues them
    function automatic void predict_send_queue(t_in it);
        logic [1:0]  ev = EV_NONE;
        logic [1:0]  err = ERR_OK;
        logic [63:0] b = {32'd0, it.byte_count};
        logic [63:0] total;
        logic [15:0] ln, off, seg;
        logic [63:0] rem;
        t_out        segs[$];
        int unsigned i;
        case (it.mode)
            MODE_APPEND: begin
                if (b == 0 || b > LEN_MAX || sh_count >= DEPTH) err = ERR_LEN;
                else if ({32'd0, sh_unsent} + b > 64'hFFFF_FFFF) err = ERR_COUNT;
                else begin
                    sh_len[4'(sh_front + sh_count)] = b[15:0];
                    sh_count++;
                    sh_unsent += b[31:0];
                    ev = update_alarm();
                end
            end
            MODE_WROTE: begin
                if (b > sh_unsent) err = ERR_COUNT;
                else begin
                    sh_unacked += b[31:0];
                    sh_unsent -= b[31:0];
                    sh_notify = 0;
                    ev = update_alarm();
                    while (sh_cur_idx < sh_count && b > 0) begin
                        ln = sh_len[4'(sh_front + sh_cur_idx)];
                        rem = (ln > sh_cur_off) ? 64'(ln - sh_cur_off) : 0;
                        if (b < rem) begin
                            sh_cur_off += b[15:0];
                            break;
                        end
                        b -= rem;
                        sh_cur_idx++;
                        sh_cur_off = 0;
                    end
                end
            end
            MODE_ACK: begin
                if (b > sh_unacked) err = ERR_COUNT;
                else begin
                    sh_unacked -= b[31:0];
                    sh_acked += b[47:0];
                    while (b > 0 && sh_count > 0 && b >= sh_len[sh_front]) begin
                        b -= sh_len[sh_front];
                        sh_front++;
                        sh_count--;
                        if (sh_cur_idx > 0) sh_cur_idx--;
                        else sh_cur_off = 0;
                    end
                    if (b > 0 && sh_count > 0) begin
                        sh_len[sh_front] -= b[15:0];
                        if (sh_cur_idx == 0)
                            sh_cur_off = (sh_cur_off >= b) ? sh_cur_off - b[15:0] : 0;
                    end
                end
            end
            MODE_REVERT: begin
                sh_unsent += sh_unacked;
                sh_unacked = 0;
                sh_cur_idx = 0;
                sh_cur_off = 0;
                if (cf_notify) sh_notify = 1;
            end
            MODE_LIST: begin
                if (sh_count == 0 || sh_unsent == 0) begin
                    expected_results.push_back(make_result(sh_notify, 0, 0, 0, 1, 0,
                                                           EV_NONE, ERR_OK));
                    return;
                end
                total = 0;
                for (i = sh_cur_idx; i < sh_count && total < b && segs.size() < MAX_SEGS;
                     i++) begin
                    ln = sh_len[4'(sh_front + i)];
                    off = (i == sh_cur_idx) ? sh_cur_off : 16'd0;
                    seg = (ln > off) ? ln - off : 16'd0;
                    segs.push_back(make_result(1, 4'(i), off, seg, 0, 0, EV_NONE, ERR_OK));
                    total += seg;
                end
                if (segs.size() == 0) begin
                    expected_results.push_back(make_result(0, 0, 0, 0, 1, 1,
                                                           EV_NONE, ERR_OK));
                    return;
                end
                foreach (segs[k]) begin
                    segs[k].more_pending = (i != sh_count);
                    segs[k].is_last = (k == segs.size() - 1);
                    expected_results.push_back(segs[k]);
                end
                return;
            end
            default: err = ERR_MODE;
        endcase
        expected_results.push_back(make_result(0, 0, 0, 0, 1, 0, ev, err));
    endfunction

    // result checker: every strobe is one transaction
    always @(posedge i_clk) begin
        t_out e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result %p", o_res);
                fail_count++;
            end else begin
                e = expected_results[0];
                expected_results.delete(0);
                if (o_res.seg_valid !== e.seg_valid) begin
                    $error("seg_valid exp %0h got %0h", e.seg_valid, o_res.seg_valid);
                    fail_count++;
                end
                if (o_res.seg_index !== e.seg_index) begin
                    $error("seg_index exp %0h got %0h", e.seg_index, o_res.seg_index);
                    fail_count++;
                end
                if (o_res.seg_offset !== e.seg_offset) begin
                    $error("seg_offset exp %0h got %0h", e.seg_offset, o_res.seg_offset);
                    fail_count++;
                end
                if (o_res.seg_length !== e.seg_length) begin
                    $error("seg_length exp %0h got %0h", e.seg_length, o_res.seg_length);
                    fail_count++;
                end
                if (o_res.is_last !== e.is_last) begin
                    $error("is_last exp %0h got %0h", e.is_last, o_res.is_last);
                    fail_count++;
                end
                if (o_res.more_pending !== e.more_pending) begin
                    $error("more_pending exp %0h got %0h", e.more_pending,
                           o_res.more_pending);
                    fail_count++;
                end
                if (o_res.unsent_bytes !== e.unsent_bytes) begin
                    $error("unsent_bytes exp %0h got %0h", e.unsent_bytes,
                           o_res.unsent_bytes);
                    fail_count++;
                end
                if (o_res.unack_bytes !== e.unack_bytes) begin
                    $error("unack_bytes exp %0h got %0h", e.unack_bytes,
                           o_res.unack_bytes);
                    fail_count++;
                end
                if (o_res.acked_total !== e.acked_total) begin
                    $error("acked_total exp %0h got %0h", e.acked_total, o_res.acked_total);
                    fail_count++;
                end
                if (o_res.alarm_on !== e.alarm_on) begin
                    $error("alarm_on exp %0h got %0h", e.alarm_on, o_res.alarm_on);
                    fail_count++;
                end
                if (o_res.alarm_event !== e.alarm_event) begin
                    $error("alarm_event exp %0h got %0h", e.alarm_event,
                           o_res.alarm_event);
                    fail_count++;
                end
                if (o_res.error !== e.error) begin
                    $error("error exp %0h got %0h", e.error, o_res.error);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one command transaction, with a random gap before it unless no_gap; start stays high
    // after acceptance until the next gap or the next drain
    task automatic send_command(logic [2:0] mode, logic [31:0] count, bit no_gap = 0);
        t_in it;
        int  gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.mode = mode;
        it.byte_count = count;
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_send_queue(it);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow_config(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // bias counts towards what the state allows
    function automatic logic [31:0] pick_count(logic [31:0] limit);
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 0;
            2: return limit;
            3: return limit + 1;
            default: return (limit == 0) ? 0 : $urandom_range(0, limit);
        endcase
    endfunction

    task automatic test_edges();
        send_command(MODE_LIST, 32'd100);
        send_command(MODE_APPEND, 32'd0);
        send_command(MODE_APPEND, 32'h0001_0000);
        send_command(MODE_APPEND, LEN_MAX);
        send_command(MODE_APPEND, 32'd1);
        send_command(MODE_LIST, 32'd0);
        send_command(MODE_LIST, 32'hFFFF_FFFF);
        send_command(MODE_WROTE, 32'hFFFF_FFFF);
        send_command(MODE_WROTE, 32'd0);
        send_command(MODE_WROTE, 32'd100);
        send_command(MODE_LIST, 32'd1);
        send_command(MODE_ACK, 32'd101);
        send_command(MODE_ACK, 32'd40);
        send_command(MODE_REVERT, 32'd0);
        send_command(3'd5, 32'd7);
        send_command(3'd6, 32'd7);
        send_command(3'd7, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++) send_command(MODE_APPEND, 32'd10, i[0]);
        send_command(MODE_LIST, 32'hFFFF_FFFF);
    endtask

    task automatic test_notify();
        write_register(REG_NOTIFY, 32'd1);
        send_command(MODE_LIST, 32'd5);
        send_command(MODE_WROTE, sh_unsent);
        send_command(MODE_LIST, 32'd5);
        send_command(MODE_REVERT, 32'd0);
        send_command(MODE_ACK, sh_unacked);
        send_command(MODE_ACK, sh_unacked);
        send_command(MODE_LIST, 32'd5);
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 30) send_command(MODE_APPEND, ($urandom_range(0, 9) == 0) ?
                                     $urandom() : $urandom_range(1, 65535));
            else if (r < 50) send_command(MODE_WROTE, pick_count(sh_unsent));
            else if (r < 68) send_command(MODE_ACK, pick_count(sh_unacked));
            else if (r < 73) send_command(MODE_REVERT, $urandom());
            else if (r < 97) send_command(MODE_LIST, pick_count(sh_unsent));
            else send_command(3'($urandom_range(5, 7)), $urandom());
            if (k == n / 2) wait_drained();
        end
    endtask

    initial begin
        shadow_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edges();
        test_notify();
        write_register(REG_ALARM, 32'd60000);
        write_register(REG_CLEAR, 32'd20000);
        write_register(REG_WM_EN, 32'd1);
        test_random(130);
        write_register(REG_ALARM, 32'hFFFF_FFFF);
        write_register(REG_CLEAR, 32'd0);
        write_register(REG_NOTIFY, 32'd0);
        test_random(130);
        write_register(REG_CLEAR, 32'hFFFF_FFFF);
        test_random(60);
        write_register(REG_WM_EN, 32'd0);
        write_register(REG_ALARM, 32'd0);
        write_register(REG_NOTIFY, 32'd1);
        test_random(50);
        wait_drained();
        if (fail_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule

// ===== stream_send_buffer_tracker_core.f =====
hw/rtl/ssbt_pkg.sv
hw/rtl/ssbt_front.sv
hw/rtl/ssbt_back.sv
hw/rtl/stream_send_buffer_tracker_core.sv
bench/stream_send_buffer_tracker_core_test.sv
